// ===== hw/rtl/sdepq_pkg.sv =====
`timescale 1ns / 1ps

package sdepq_pkg;

    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 16;
    localparam int HANDLE_BITS = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP_MAX  = 3'd1,
        CMD_POP_MIN  = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_READ_ALL = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP_MAX,
        CELL_SHIFT,
        CELL_ROTATE,
        CELL_CLEAR
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic signed [PRIO_BITS-1:0] prio;
        logic [HANDLE_BITS-1:0]      handle;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   key;
    } cell_ctl_t;

    // What one cell shows to its neighbors
    typedef struct packed {
        entry_t ent;
        logic   occ;
        logic   mv;
    } cell_link_t;

    typedef struct packed {
        status_t                status;
        logic                   entry_valid;
        logic [PRIO_BITS-1:0]   entry_priority;
        logic [HANDLE_BITS-1:0] entry_handle;
        logic [CNT_W-1:0]       occupancy;
        logic                   run_last;
    } result_t;

    // Virtual neighbors at both ends of the chain
    localparam cell_link_t LINK_HEAD = '{ent: '0, occ: 1'b1, mv: 1'b0};
    localparam cell_link_t LINK_TAIL = '{ent: '0, occ: 1'b0, mv: 1'b1};

endpackage

// ===== hw/rtl/sdepq_cell.sv =====
`timescale 1ns / 1ps

module sdepq_cell import sdepq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctl_t  ctl,
    input  entry_t     wrap,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t link
);

    entry_t ent_reg, ent_next;
    logic   occ_reg, occ_next;
    logic   mv;

    // Entry moves up on insert: empty, or strictly above the new key
    assign mv = !occ_reg || ($signed(ent_reg.prio) > $signed(ctl.key.prio));

    always_comb begin
        ent_next = ent_reg;
        occ_next = occ_reg;
        unique case (ctl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (mv) begin
                    ent_next = left.mv ? left.ent : ctl.key;
                end
                occ_next = occ_reg | left.occ;
            end
            CELL_POP_MAX: begin
                occ_next = right.occ;
            end
            CELL_SHIFT: begin
                ent_next = right.ent;
                occ_next = right.occ;
            end
            CELL_ROTATE: begin
                if (right.occ) begin
                    ent_next = right.ent;
                end else if (occ_reg) begin
                    ent_next = wrap;
                end
            end
            CELL_CLEAR: begin
                occ_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign link.ent = ent_reg;
    assign link.occ = occ_reg;
    assign link.mv  = mv;

endmodule

// ===== hw/rtl/sdepq_ctrl.sv =====
`timescale 1ns / 1ps

module sdepq_ctrl import sdepq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_cmd,
    input  logic [PRIO_BITS-1:0]   s_key_priority,
    input  logic [HANDLE_BITS-1:0] s_object_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic                   m_entry_valid,
    output logic [PRIO_BITS-1:0]   m_entry_priority,
    output logic [HANDLE_BITS-1:0] m_entry_handle,
    output logic [CNT_W-1:0]       m_occupancy,
    output logic                   m_run_last,
    input  entry_t                 head,
    input  entry_t                 tail,
    output cell_ctl_t              cell_ctl
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] left_reg, left_next;
    result_t          res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;
    logic             accept;
    logic             load;
    cell_op_t         op;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (cmd_t'(s_cmd) == CMD_READ_ALL) && (cnt_reg != '0)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (out_free && (left_reg == CNT_W'(1))) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: result, cell operation, counters
    always_comb begin
        load      = 1'b0;
        op        = CELL_HOLD;
        cnt_next  = cnt_reg;
        left_next = left_reg;
        res_next  = '{status: STAT_OK, entry_valid: 1'b0, entry_priority: '0,
                      entry_handle: '0, occupancy: cnt_reg, run_last: 1'b1};
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    load = 1'b1;
                    unique case (cmd_t'(s_cmd))
                        CMD_INSERT: begin
                            if (cnt_reg == CNT_W'(DEPTH)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                op       = CELL_INSERT;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_MAX: begin
                            if (cnt_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                op                      = CELL_POP_MAX;
                                cnt_next                = cnt_reg - CNT_W'(1);
                                res_next.entry_valid    = 1'b1;
                                res_next.entry_priority = tail.prio;
                                res_next.entry_handle   = tail.handle;
                            end
                        end
                        CMD_POP_MIN: begin
                            if (cnt_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                op                      = CELL_SHIFT;
                                cnt_next                = cnt_reg - CNT_W'(1);
                                res_next.entry_valid    = 1'b1;
                                res_next.entry_priority = head.prio;
                                res_next.entry_handle   = head.handle;
                            end
                        end
                        CMD_CLEAR: begin
                            op       = CELL_CLEAR;
                            cnt_next = '0;
                        end
                        CMD_READ_ALL: begin
                            if (cnt_reg == '0) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                load      = 1'b0;
                                left_next = cnt_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                    res_next.occupancy = cnt_next;
                end
            end
            S_READ: begin
                if (out_free) begin
                    load                    = 1'b1;
                    op                      = CELL_ROTATE;
                    left_next               = left_reg - CNT_W'(1);
                    res_next.entry_valid    = 1'b1;
                    res_next.entry_priority = head.prio;
                    res_next.entry_handle   = head.handle;
                    res_next.run_last       = (left_reg == CNT_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign cell_ctl.op         = op;
    assign cell_ctl.key.prio   = s_key_priority;
    assign cell_ctl.key.handle = s_object_handle;

    assign m_valid          = m_valid_reg;
    assign m_status         = res_reg.status;
    assign m_entry_valid    = res_reg.entry_valid;
    assign m_entry_priority = res_reg.entry_priority;
    assign m_entry_handle   = res_reg.entry_handle;
    assign m_occupancy      = res_reg.occupancy;
    assign m_run_last       = res_reg.run_last;

endmodule

// ===== hw/rtl/sorted_double_ended_priority_queue_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_       in   s_valid / s_ready  s_cmd, s_key_priority, s_object_handle
// m_       out  m_valid / m_ready  m_status, m_entry_valid, m_entry_priority,
//                                  m_entry_handle, m_occupancy, m_run_last
//
// Insert, pop max, pop min and clear act on all cells at once: on insert every
// cell compares its entry against the broadcast key and shifts in one step, so one
// command is taken per cycle while the result register drains.
// Read-all streams one entry per cycle, unless the m_ side stalls, by rotating the
// occupied cells toward the head; s_ready stays low meanwhile.
// Reset (aresetn, synchronous, active low) empties the queue; slot payload
// is not cleared.
// A stalled m_ side holds the result register and blocks the next transfer.

module sorted_double_ended_priority_queue_top import sdepq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_cmd,
    input  logic [PRIO_BITS-1:0]   s_key_priority,
    input  logic [HANDLE_BITS-1:0] s_object_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic                   m_entry_valid,
    output logic [PRIO_BITS-1:0]   m_entry_priority,
    output logic [HANDLE_BITS-1:0] m_entry_handle,
    output logic [CNT_W-1:0]       m_occupancy,
    output logic                   m_run_last
);

    cell_ctl_t        cell_ctl;
    cell_link_t       links [DEPTH];
    logic [DEPTH:0]   occ_vec;
    logic [DEPTH-1:0] tail_hit;
    entry_t           tail;

    // Sorted chain, cell 0 holds the minimum
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_link_t left_l, right_l;
        if (i == 0) begin : g_head
            assign left_l = LINK_HEAD;
        end else begin : g_mid_l
            assign left_l = links[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_l = LINK_TAIL;
        end else begin : g_mid_r
            assign right_l = links[i+1];
        end

        sdepq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cell_ctl),
            .wrap    (links[0].ent),
            .left    (left_l),
            .right   (right_l),
            .link    (links[i])
        );

        assign occ_vec[i] = links[i].occ;
    end
    assign occ_vec[DEPTH] = 1'b0;

    // Last occupied cell is the maximum
    always_comb begin
        tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_hit[i] = occ_vec[i] && !occ_vec[i+1];
            if (tail_hit[i]) begin
                tail = links[i].ent;
            end
        end
    end

    sdepq_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_key_priority   (s_key_priority),
        .s_object_handle  (s_object_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_valid    (m_entry_valid),
        .m_entry_priority (m_entry_priority),
        .m_entry_handle   (m_entry_handle),
        .m_occupancy      (m_occupancy),
        .m_run_last       (m_run_last),
        .head             (links[0].ent),
        .tail             (tail),
        .cell_ctl         (cell_ctl)
    );

`ifndef NO_ASSERTIONS
    // Occupied cells always form a contiguous run from the head
    a_occ_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec + 1'b1) & occ_vec) == '0)
        else $error("occupied cells not contiguous");

    // At most one cell can be the tail
    a_tail_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tail_hit))
        else $error("more than one tail cell");

    // Reported occupancy never exceeds the chain length
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy out of range");

    // An empty or full status never carries an entry
    a_no_entry_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_EMPTY || m_status == STAT_FULL))
            |-> !m_entry_valid)
        else $error("entry on error status");
`endif

endmodule
